### hw/rtl/audio_echo_and_modulation_assert.svh
// Assertion macros for the audio echo and modulation RTL.
// Included by the top module, the only one with checks; no other dependencies.
`ifndef AUDIO_ECHO_AND_MODULATION_ASSERT_SVH
`define AUDIO_ECHO_AND_MODULATION_ASSERT_SVH

`ifndef NO_ASSERTIONS

// A condition that must hold at every clock edge outside reset.
`define AEM_ASSERT(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("audio_echo_and_modulation: assertion failed");

// Same-cycle implication.
`define AEM_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("audio_echo_and_modulation: assertion failed");

// Next-cycle implication.
`define AEM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("audio_echo_and_modulation: assertion failed");

`else

`define AEM_ASSERT(label, clk, rst, expr)
`define AEM_ASSERT_IMPL(label, clk, rst, ante, cons)
`define AEM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### hw/rtl/aem_pkg.sv
// Package for the audio echo and modulation block: types, codes, constants,
// the sat16 clamp and the elaboration-time cosine function. No dependencies.
`default_nettype none

package aem_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_EFFECT_MODE = 2'd0;
  localparam logic [1:0] CFG_ECHO_GAIN   = 2'd1;
  localparam logic [1:0] CFG_ECHO_DELAY  = 2'd2;
  localparam logic [1:0] CFG_PHASE_STEP  = 2'd3;

  // Effect modes.
  localparam logic [1:0] MODE_SINGLE_ECHO = 2'd0;
  localparam logic [1:0] MODE_MULTI_ECHO  = 2'd1;
  localparam logic [1:0] MODE_AMP_MOD     = 2'd2;
  localparam logic [1:0] MODE_BYPASS      = 2'd3;

  // Echo divider: the quotient never exceeds 32768, so 17 quotient bits suffice.
  localparam int DIVIDEND_BITS = 32;
  localparam int QUO_BITS      = 17;
  localparam int DEN_BITS      = 17;
  localparam int STEP_BITS     = 5;

  // Fixed-point constants for the cosine series.
  localparam longint Q30_ONE        = 64'sd1073741824;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam longint TAYLOR_DIV [6] = '{64'sd132, 64'sd90, 64'sd56, 64'sd30, 64'sd12, 64'sd2};

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_MIX,
    S_DIV,
    S_DONE
  } aem_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } aem_div_stat_t;

  // Clamp a wide signed value to the 16-bit PCM range.
  function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
    logic signed [15:0] r;
    if (v > 34'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -34'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Q1.15 cosine of m * 2pi / 2^table_bits for m in the first quarter wave.
  // Taylor series to theta^12 in Horner form, Q2.30, truncating divisions,
  // then rounded half away from zero. Evaluated only with constant arguments.
  function automatic logic signed [16:0] cos_coef_q15(input int unsigned m,
                                                      input int unsigned table_bits);
    logic [63:0] wide;
    longint theta;
    longint t2;
    longint acc;
    longint c15;
    wide  = 64'(m) * TWO_PI_Q30;
    theta = longint'(wide >> table_bits);
    t2    = (theta * theta) / Q30_ONE;
    acc   = Q30_ONE;
    for (int k = 0; k < 6; k++) begin
      acc = Q30_ONE - ((t2 * acc) / Q30_ONE) / TAYLOR_DIV[k];
    end
    if (acc >= 0) begin
      c15 = (acc + 16384) / 32768;
    end else begin
      c15 = -((-acc + 16384) / 32768);
    end
    if (c15 > 32768) begin
      c15 = 32768;
    end
    if (c15 < -32768) begin
      c15 = -32768;
    end
    return 17'(c15);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/aem_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the echo delay line.
`default_nettype none

module aem_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/aem_divider.sv
// Restoring unsigned divider, one quotient bit per cycle, for the echo mix.
// Depends on aem_pkg for widths and the status struct.
`default_nettype none

module aem_divider (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  input  wire logic [aem_pkg::DIVIDEND_BITS-1:0]    dividend,
  input  wire logic [aem_pkg::DEN_BITS-1:0]         divisor,
  output logic      [aem_pkg::QUO_BITS-1:0]         quotient,
  output aem_pkg::aem_div_stat_t                    stat
);

  localparam int HI_BITS = aem_pkg::DIVIDEND_BITS - aem_pkg::QUO_BITS;

  logic [aem_pkg::STEP_BITS-1:0] count;
  logic [aem_pkg::DEN_BITS-1:0]  rem;
  logic [aem_pkg::DEN_BITS-1:0]  den;
  logic [aem_pkg::QUO_BITS-1:0]  dq;
  logic                          busy;
  logic                          done;

  logic [aem_pkg::DEN_BITS:0]    trial;
  logic                          ge;
  logic [aem_pkg::DEN_BITS:0]    diff;

  // The dividend is known to be below divisor * 2^QUO_BITS, so the remainder
  // can start from its upper bits and only QUO_BITS steps are needed.
  always_comb begin
    trial = {rem, dq[aem_pkg::QUO_BITS-1]};
    ge    = trial >= {1'b0, den};
    diff  = trial - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= aem_pkg::STEP_BITS'(aem_pkg::QUO_BITS);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == aem_pkg::STEP_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= aem_pkg::DEN_BITS'(dividend[aem_pkg::DIVIDEND_BITS-1 -: HI_BITS]);
      dq  <= dividend[aem_pkg::QUO_BITS-1:0];
      den <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[aem_pkg::DEN_BITS-1:0] : trial[aem_pkg::DEN_BITS-1:0];
      dq  <= {dq[aem_pkg::QUO_BITS-2:0], ge};
    end
  end

  assign quotient  = dq;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

### hw/rtl/audio_echo_and_modulation.sv
// Top level of the audio echo and modulation block: sequencer, shared
// multiplier, delay line RAM and echo divider. Depends on aem_pkg, aem_ram,
// aem_divider and audio_echo_and_modulation_assert.svh.
//
//   Channel  Direction  Handshake                Payload
//   ------   ---------  -----------------------  -----------------------------
//   input    in         in_valid / in_stall      sample_in  (signed 16 bits)
//   output   out        out_valid / out_stall    sample_out (signed 16 bits)
//   config   in         cfg_write                cfg_index (2), cfg_data (32)
//
// A sample that passes straight through goes from S_MUL to S_DONE; an echo
// goes through S_MUL, S_MIX and S_DIV, which waits on the 17 steps of the
// bit-serial divider; amplitude modulation goes through S_MUL and S_MIX.
// The block takes no new sample (in_stall high) from acceptance until the
// result has been moved into the output register. The output register lets
// the next sample be accepted while a result still waits on out_stall.
// Reset is synchronous; the delay line needs no clearing pass because an
// entry is read only after it has been written.
`default_nettype none

`include "audio_echo_and_modulation_assert.svh"

module audio_echo_and_modulation #(
  parameter int MAX_DELAY      = 4096,
  parameter int COS_TABLE_BITS = 10
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // Input sample channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] sample_in,
  // Output sample channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      sample_out,
  // Configuration write port
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  localparam int AW      = MAX_DELAY > 1 ? $clog2(MAX_DELAY) : 1;
  localparam int SW      = $clog2(MAX_DELAY + 1);
  localparam int QUARTER = 1 << (COS_TABLE_BITS - 2);
  localparam int MW      = COS_TABLE_BITS - 1;

  // Configuration registers.
  logic [1:0]  effect_mode;
  logic [15:0] echo_gain;
  logic [11:0] echo_delay;
  logic [31:0] phase_step;

  // History that runs across every sample, whatever the mode.
  logic [AW-1:0]        wp;
  logic [SW-1:0]        samples_seen;
  logic signed [15:0]   previous_output;
  logic                 first_pending;
  logic [31:0]          phase_accumulator;

  // Per-sample working registers.
  aem_pkg::aem_state_t  state;
  aem_pkg::aem_state_t  state_next;
  logic signed [15:0]   x;
  logic                 pass;
  logic signed [16:0]   cos_q;
  logic signed [33:0]   prod;
  logic                 num_neg;
  logic signed [15:0]   res_y;

  logic                 accept;
  logic                 div_start;
  logic                 out_load;
  logic                 out_free;

  // Delay handling. The delay is clamped to MAX_DELAY - 1.
  logic [16:0]          d_wide;
  logic [16:0]          d_clamp;
  logic                 d_zero;
  logic [17:0]          rd_sum;
  logic [AW-1:0]        raddr;
  logic [15:0]          ram_rdata;
  logic                 pass_now;

  // Cosine lookup. The phase's top bits pick a quadrant and an index into a
  // quarter-wave table; the second and third quadrants negate the entry.
  logic signed [16:0]   cos_rom [QUARTER+1];
  logic [COS_TABLE_BITS-1:0] p;
  logic [1:0]           quad;
  logic [MW-1:0]        m;

  // Shared multiplier operands.
  logic signed [16:0]   mul_a;
  logic signed [16:0]   mul_b;
  logic signed [15:0]   h;

  // Mix and scale.
  logic signed [33:0]   num;
  logic signed [33:0]   num_abs;
  logic signed [33:0]   mod_scaled;
  logic [aem_pkg::DEN_BITS-1:0] den;
  logic [aem_pkg::QUO_BITS-1:0] quotient;
  logic signed [33:0]   quo_signed;
  aem_pkg::aem_div_stat_t div_stat;

  for (genvar i = 0; i <= QUARTER; i++) begin : g_cos_rom
    assign cos_rom[i] = aem_pkg::cos_coef_q15(i, COS_TABLE_BITS);
  end

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != aem_pkg::S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    d_wide  = {5'd0, echo_delay};
    d_clamp = (d_wide > 17'(MAX_DELAY - 1)) ? 17'(MAX_DELAY - 1) : d_wide;
    d_zero  = (d_clamp == 17'd0);
    rd_sum  = 18'(wp) + 18'(MAX_DELAY) - 18'(d_clamp);
    if (rd_sum >= 18'(MAX_DELAY)) begin
      rd_sum = rd_sum - 18'(MAX_DELAY);
    end
    raddr = rd_sum[AW-1:0];
  end

  // Decide at acceptance whether the sample simply passes through, from the
  // history as it stands before this sample is counted.
  always_comb begin
    case (effect_mode)
      aem_pkg::MODE_SINGLE_ECHO: pass_now = 18'(samples_seen) < 18'(d_clamp);
      aem_pkg::MODE_MULTI_ECHO:  pass_now = first_pending;
      aem_pkg::MODE_AMP_MOD:     pass_now = 1'b0;
      default:                   pass_now = 1'b1;
    endcase
  end

  always_comb begin
    p    = phase_accumulator[31 -: COS_TABLE_BITS];
    quad = p[COS_TABLE_BITS-1 -: 2];
    m    = quad[0] ? (MW'(QUARTER) - MW'(p[COS_TABLE_BITS-3:0]))
                   : MW'(p[COS_TABLE_BITS-3:0]);
  end

  // Operand selection for the one multiplier: gain times echo source for the
  // echo modes, cosine coefficient times sample for modulation.
  always_comb begin
    if (effect_mode == aem_pkg::MODE_MULTI_ECHO) begin
      h = previous_output;
    end else if (d_zero) begin
      h = x;
    end else begin
      h = $signed(ram_rdata);
    end
    if (effect_mode == aem_pkg::MODE_AMP_MOD) begin
      mul_a = cos_q;
      mul_b = 17'(x);
    end else begin
      mul_a = $signed({1'b0, echo_gain});
      mul_b = 17'(h);
    end
  end

  always_comb begin
    num        = ($signed(34'(x)) <<< 8) + prod;
    num_abs    = num[33] ? -num : num;
    den        = {1'b0, echo_gain} + 17'd256;
    // Division by 32768 truncating toward zero.
    mod_scaled = (prod + (prod[33] ? 34'sd32767 : 34'sd0)) >>> 15;
    quo_signed = num_neg ? -$signed({17'd0, quotient}) : $signed({17'd0, quotient});
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      aem_pkg::S_IDLE: begin
        if (accept) begin
          state_next = aem_pkg::S_MUL;
        end
      end
      aem_pkg::S_MUL: begin
        state_next = pass ? aem_pkg::S_DONE : aem_pkg::S_MIX;
      end
      aem_pkg::S_MIX: begin
        if (effect_mode == aem_pkg::MODE_AMP_MOD) begin
          state_next = aem_pkg::S_DONE;
        end else begin
          div_start  = 1'b1;
          state_next = aem_pkg::S_DIV;
        end
      end
      aem_pkg::S_DIV: begin
        if (div_stat.done) begin
          state_next = aem_pkg::S_DONE;
        end
      end
      aem_pkg::S_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = aem_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = aem_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aem_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration and history registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      effect_mode       <= aem_pkg::MODE_SINGLE_ECHO;
      echo_gain         <= 16'd128;
      echo_delay        <= 12'd0;
      phase_step        <= 32'd0;
      wp                <= '0;
      samples_seen      <= '0;
      previous_output   <= '0;
      first_pending     <= 1'b1;
      phase_accumulator <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          aem_pkg::CFG_EFFECT_MODE: effect_mode <= cfg_data[1:0];
          aem_pkg::CFG_ECHO_GAIN:   echo_gain   <= cfg_data[15:0];
          aem_pkg::CFG_ECHO_DELAY:  echo_delay  <= cfg_data[11:0];
          aem_pkg::CFG_PHASE_STEP:  phase_step  <= cfg_data;
          default: begin
          end
        endcase
      end
      if (accept) begin
        wp <= (wp == AW'(MAX_DELAY - 1)) ? '0 : wp + 1'b1;
        if (samples_seen != SW'(MAX_DELAY)) begin
          samples_seen <= samples_seen + 1'b1;
        end
        first_pending     <= 1'b0;
        phase_accumulator <= phase_accumulator + phase_step;
      end
      if (out_load) begin
        previous_output <= res_y;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      x     <= sample_in;
      pass  <= pass_now;
      cos_q <= (quad inside {2'd1, 2'd2}) ? -cos_rom[m] : cos_rom[m];
    end
    case (state)
      aem_pkg::S_MUL: begin
        if (pass) begin
          res_y <= x;
        end else begin
          prod <= mul_a * mul_b;
        end
      end
      aem_pkg::S_MIX: begin
        num_neg <= num[33];
        if (effect_mode == aem_pkg::MODE_AMP_MOD) begin
          res_y <= aem_pkg::sat16(mod_scaled);
        end
      end
      aem_pkg::S_DIV: begin
        if (div_stat.done) begin
          res_y <= aem_pkg::sat16(quo_signed);
        end
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample_out <= res_y;
    end
  end

  // The delay line takes each accepted sample at the write pointer while the
  // echo tap is read at the same edge.
  aem_ram #(
    .WIDTH (16),
    .DEPTH (MAX_DELAY)
  ) u_delay_line (
    .clk   (clk),
    .we    (accept),
    .waddr (wp),
    .wdata (sample_in),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  aem_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (num_abs[aem_pkg::DIVIDEND_BITS-1:0]),
    .divisor  (den),
    .quotient (quotient),
    .stat     (div_stat)
  );

  `AEM_ASSERT(a_seen_bounded, clk, rst, samples_seen <= SW'(MAX_DELAY))
  `AEM_ASSERT_IMPL(a_div_done_in_div, clk, rst, div_stat.done, state == aem_pkg::S_DIV)
  `AEM_ASSERT_IMPL(a_out_from_done, clk, rst, $rose(out_valid), $past(state) == aem_pkg::S_DONE)
  `AEM_ASSERT_NEXT(a_first_cleared, clk, rst, accept, !first_pending && state == aem_pkg::S_MUL)

endmodule

`default_nettype wire
